[src/pdtx_pkg.sv]
// ============================================================================
// pdtx_pkg - shared types and constants for the PD transmit frame packer
// 4b5b symbol table, command format between the front and back halves,
// and the back-end phase encoding.
// ============================================================================
package pdtx_pkg;

    localparam int LINE_BITS      = 16;   // line bits per output word
    localparam int WORD_W         = 32;
    localparam int SYM_W          = 5;    // bits per 4b5b symbol
    localparam int SYM_BUF_W      = 15;   // up to three symbols per request
    localparam int POS_W          = 4;
    localparam int BYTES_W        = 10;
    localparam int OS_CNT_W       = 3;
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_W      = 2;
    localparam int CMD_CNT_W      = 3;

    localparam logic [OS_CNT_W-1:0] OS_PER_FRAME = 3'd4;
    localparam logic [7:0]          KCODE_EOP    = 8'd20;

    localparam logic KIND_ORDERED_SET = 1'b0;
    localparam logic KIND_PAYLOAD     = 1'b1;

    // one unit of back-end work: pad, preamble, then symbol bits
    typedef struct packed {
        logic [3:0]           pad_cnt;
        logic                 preamble;
        logic [SYM_BUF_W-1:0] sym;
        logic [3:0]           sym_cnt;
        logic                 last;
        logic                 drop;
        logic                 lerr;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_PAD,
        PH_PRE,
        PH_SYM
    } t_phase;

    // K-code index to 4b5b line code; unknown indices give zero bits
    function automatic logic [SYM_W-1:0] sym_code(input logic [7:0] idx);
        logic [SYM_W-1:0] code;
        case (idx)
            8'd0:    code = 5'h1E;
            8'd1:    code = 5'h09;
            8'd2:    code = 5'h14;
            8'd3:    code = 5'h15;
            8'd4:    code = 5'h0A;
            8'd5:    code = 5'h0B;
            8'd6:    code = 5'h0E;
            8'd7:    code = 5'h0F;
            8'd8:    code = 5'h12;
            8'd9:    code = 5'h13;
            8'd10:   code = 5'h16;
            8'd11:   code = 5'h17;
            8'd12:   code = 5'h1A;
            8'd13:   code = 5'h1B;
            8'd14:   code = 5'h1C;
            8'd15:   code = 5'h1D;
            8'd16:   code = 5'h18;
            8'd17:   code = 5'h11;
            8'd18:   code = 5'h07;
            8'd19:   code = 5'h19;
            8'd20:   code = 5'h0D;
            8'd21:   code = 5'h06;
            default: code = 5'h00;
        endcase
        return code;
    endfunction

endpackage

[src/pd_bmc_tx_frame_packer.sv]
// ============================================================================
// pd_bmc_tx_frame_packer - USB PD transmit framer, 4b5b line words
// Ordered-set K-codes and payload bytes in, 32-bit line words out
// (pad, preamble, 4b5b symbols, EOP; pairs {1, bit}).
// ============================================================================
//
//  channel   dir  handshake                  payload
//  -------   ---  -------------------------  ----------------------------------
//  in        in   i_in_valid / o_in_ready    kind, value, num_data_objects,
//                                            ext_bytes, last
//  out       out  o_out_valid / i_out_ready  line_word, end_of_frame,
//                                            length_error
//
//  Pacing: the packer moves up to one word's room of line bits per cycle
//  unless the output stalls; the first ordered-set request also carries
//  the pad and the preamble ahead of its symbol.
//  The four-entry command queue lets input run ahead of the packer.
//  Reset: synchronous, active low; clears frame state, queue and output valid.
//  Stalls: a full output register stops the packer only when it must hand off
//  a word; a full queue drops o_in_ready.
//
module pd_bmc_tx_frame_packer #(
    parameter int PREAMBLE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_value,
    input  logic [2:0]  i_num_data_objects,
    input  logic [8:0]  i_ext_bytes,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_line_word,
    output logic        o_end_of_frame,
    output logic        o_length_error
);
    import pdtx_pkg::*;

    t_cmd                 w_cmd;
    t_cmd                 w_head;
    logic                 w_cmd_push;
    logic                 w_cmd_pop;
    logic                 w_cmd_empty;
    logic                 w_cmd_full;
    logic [CMD_CNT_W-1:0] w_cmd_count;

    // front: frame bookkeeping, one command per request that makes line bits
    pdtx_front #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_value            (i_value),
        .i_num_data_objects (i_num_data_objects),
        .i_ext_bytes        (i_ext_bytes),
        .i_last             (i_last),
        .i_cmd_full         (w_cmd_full),
        .o_cmd_push         (w_cmd_push),
        .o_cmd              (w_cmd)
    );

    // decoupling queue
    pdtx_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_cmd_pop),
        .o_head  (w_head),
        .o_empty (w_cmd_empty),
        .o_full  (w_cmd_full),
        .o_count (w_cmd_count)
    );

    // back: bit packing into line words, output register
    pdtx_back #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_head_valid   (!w_cmd_empty),
        .o_pop          (w_cmd_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_line_word    (o_line_word),
        .o_end_of_frame (o_end_of_frame),
        .o_length_error (o_length_error)
    );

    // final word has bit 31 toggled, every other word keeps it set
    a_eof_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_word[31] != o_end_of_frame))
        else $error("bit 31 disagrees with end_of_frame");

    // clock half of each pair is always 1 below bit 31
    a_pair_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_line_word & 32'h2AAA_AAAA) == 32'h2AAA_AAAA))
        else $error("line word pair pattern broken");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_count <= CMD_CNT_W'(CMD_FIFO_DEPTH))
        else $error("command queue overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_cmd_count != '0))
        else $error("pop from empty command queue");

endmodule

[src/pdtx_front.sv]
// ============================================================================
// pdtx_front - request classifier
// Tracks frame state (ordered-set count, bytes left, drop flag) and turns
// each accepted request that makes line bits into a bit-packing command.
// ============================================================================
module pdtx_front #(
    parameter int PREAMBLE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [7:0]            i_value,
    input  logic [2:0]            i_num_data_objects,
    input  logic [8:0]            i_ext_bytes,
    input  logic                  i_last,
    input  logic                  i_cmd_full,
    output logic                  o_cmd_push,
    output pdtx_pkg::t_cmd        o_cmd
);
    import pdtx_pkg::*;

    logic                r_in_frame, n_in_frame;
    logic [OS_CNT_W-1:0] r_os_count, n_os_count;
    logic [BYTES_W-1:0]  r_bytes_rem, n_bytes_rem;
    logic                r_dropped, n_dropped;

    logic               w_accept;
    logic               w_push;
    logic [BYTES_W-1:0] w_payload;
    logic [15:0]        w_x;
    logic [15:0]        w_tot;
    logic [15:0]        w_neg;
    logic [SYM_W-1:0]   w_os_sym;
    logic [SYM_W-1:0]   w_lo_sym;
    logic [SYM_W-1:0]   w_hi_sym;
    logic [SYM_W-1:0]   w_eop_sym;

    assign w_accept  = i_in_valid && !i_cmd_full;
    assign o_in_ready = !i_cmd_full;

    // payload bytes = header + data objects + extended part + CRC
    assign w_payload = 10'd6 + {5'b0, i_num_data_objects, 2'b00} + {1'b0, i_ext_bytes};
    assign w_x       = {5'b0, w_payload, 1'b0} + 16'd5;
    assign w_tot     = 16'(PREAMBLE_BITS) + {w_x[13:0], 2'b00} + w_x;
    assign w_neg     = 16'd0 - w_tot;

    assign w_os_sym  = sym_code(i_value);
    assign w_lo_sym  = sym_code({4'b0, i_value[3:0]});
    assign w_hi_sym  = sym_code({4'b0, i_value[7:4]});
    assign w_eop_sym = sym_code(KCODE_EOP);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_os_count  = r_os_count;
        n_bytes_rem = r_bytes_rem;
        n_dropped   = r_dropped;
        w_push      = 1'b0;
        o_cmd       = '0;
        if (i_kind == KIND_ORDERED_SET) begin
            if (!r_in_frame) begin
                n_in_frame    = 1'b1;
                n_dropped     = 1'b0;
                n_bytes_rem   = w_payload;
                n_os_count    = 3'd1;
                o_cmd.pad_cnt  = w_neg[3:0];
                o_cmd.preamble = 1'b1;
                o_cmd.sym      = {10'b0, w_os_sym};
                o_cmd.sym_cnt  = 4'd5;
                w_push         = 1'b1;
            end else if (r_os_count < OS_PER_FRAME) begin
                n_os_count    = r_os_count + 3'd1;
                o_cmd.sym     = {10'b0, w_os_sym};
                o_cmd.sym_cnt = 4'd5;
                w_push        = 1'b1;
            end else begin
                n_dropped = 1'b1;
            end
            o_cmd.drop = n_dropped;
        end else if (r_in_frame) begin
            n_os_count = OS_PER_FRAME;
            if (r_bytes_rem != '0) begin
                n_bytes_rem   = r_bytes_rem - 10'd1;
                o_cmd.sym     = {5'b0, w_hi_sym, w_lo_sym};
                o_cmd.sym_cnt = 4'd10;
                w_push        = 1'b1;
            end else begin
                n_dropped = 1'b1;
            end
            o_cmd.drop = n_dropped;
            if (i_last) begin
                if (r_bytes_rem != '0) begin
                    o_cmd.sym     = {w_eop_sym, w_hi_sym, w_lo_sym};
                    o_cmd.sym_cnt = 4'd15;
                end else begin
                    o_cmd.sym     = {10'b0, w_eop_sym};
                    o_cmd.sym_cnt = 4'd5;
                end
                o_cmd.last  = 1'b1;
                o_cmd.lerr  = n_dropped || (n_bytes_rem != '0);
                w_push      = 1'b1;
                // frame closes: back to idle
                n_in_frame  = 1'b0;
                n_os_count  = '0;
                n_bytes_rem = '0;
                n_dropped   = 1'b0;
            end
        end
    end

    assign o_cmd_push = w_accept && w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_os_count  <= '0;
            r_bytes_rem <= '0;
            r_dropped   <= 1'b0;
        end else if (w_accept) begin
            r_in_frame  <= n_in_frame;
            r_os_count  <= n_os_count;
            r_bytes_rem <= n_bytes_rem;
            r_dropped   <= n_dropped;
        end
    end

endmodule

[src/pdtx_cmd_fifo.sv]
// ============================================================================
// pdtx_cmd_fifo - command queue between front and back
// Small register FIFO; head is read in place and popped when finished.
// ============================================================================
module pdtx_cmd_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  pdtx_pkg::t_cmd                i_cmd,
    input  logic                          i_pop,
    output pdtx_pkg::t_cmd                o_head,
    output logic                          o_empty,
    output logic                          o_full,
    output logic [pdtx_pkg::CMD_CNT_W-1:0] o_count
);
    import pdtx_pkg::*;

    t_cmd                 r_mem [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= CMD_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= CMD_PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/pdtx_back.sv]
// ============================================================================
// pdtx_back - line bit packer
// Walks pad, preamble, symbol bits of the head command, up to one word's room
// per cycle unless stalled; hands full and final words to the output register.
// ============================================================================
module pdtx_back #(
    parameter int PREAMBLE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdtx_pkg::t_cmd        i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_line_word,
    output logic                  o_end_of_frame,
    output logic                  o_length_error
);
    import pdtx_pkg::*;

    localparam int   REM_W   = $clog2(PREAMBLE_BITS + 1);
    localparam logic PRE_ODD = (PREAMBLE_BITS % 2) == 1;

    logic                 r_busy, n_busy;
    t_phase               r_phase, n_phase;
    logic [REM_W-1:0]     r_remain, n_remain;
    logic [SYM_BUF_W-1:0] r_sym, n_sym;
    logic [LINE_BITS-1:0] r_acc, n_acc;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_W-1:0]    r_line_word, n_line_word;
    logic                 r_eof, n_eof;
    logic                 r_lerr, n_lerr;

    t_phase               w_phase;
    logic [REM_W-1:0]     w_remain;
    logic [SYM_BUF_W-1:0] w_sym;
    logic [4:0]           w_room;
    logic [4:0]           w_take;
    logic [LINE_BITS-1:0] w_src;
    logic [LINE_BITS-1:0] w_mask;
    logic [LINE_BITS-1:0] w_ins;
    logic [LINE_BITS-1:0] w_acc_new;
    logic                 w_word_full;
    logic                 w_seg_done;
    logic                 w_final;
    logic                 w_emit;
    logic                 w_step;

    // data bit i at 2i, a 1 at 2i+1
    function automatic logic [WORD_W-1:0] to_line(input logic [LINE_BITS-1:0] d);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < LINE_BITS; i++) begin
            w[2*i]   = d[i];
            w[2*i+1] = 1'b1;
        end
        return w;
    endfunction

    // effective segment: registers while busy, else straight from the head
    always_comb begin
        w_phase  = r_phase;
        w_remain = r_remain;
        w_sym    = r_sym;
        if (!r_busy) begin
            w_sym = i_head.sym;
            if (i_head.pad_cnt != '0) begin
                w_phase  = PH_PAD;
                w_remain = REM_W'(i_head.pad_cnt);
            end else if (i_head.preamble) begin
                w_phase  = PH_PRE;
                w_remain = REM_W'(PREAMBLE_BITS);
            end else begin
                w_phase  = PH_SYM;
                w_remain = REM_W'(i_head.sym_cnt);
            end
        end
    end

    assign w_room = 5'd16 - {1'b0, r_pos};
    assign w_take = (w_remain < REM_W'(w_room)) ? w_remain[4:0] : w_room;

    always_comb begin
        case (w_phase)
            PH_PAD:  w_src = '0;
            // preamble bit index i = PREAMBLE_BITS - remain, value i & 1
            PH_PRE:  w_src = (PRE_ODD ^ w_remain[0]) ? 16'h5555 : 16'hAAAA;
            PH_SYM:  w_src = {1'b0, w_sym};
            default: w_src = '0;
        endcase
    end

    assign w_mask      = 16'((17'd1 << w_take) - 17'd1);
    assign w_ins       = (w_src & w_mask) << r_pos;
    assign w_acc_new   = r_acc | w_ins;
    assign w_word_full = ({1'b0, r_pos} + w_take) == 5'd16;
    assign w_seg_done  = (REM_W'(w_take) == w_remain);
    assign w_final     = w_seg_done && (w_phase == PH_SYM) && i_head.last;
    assign w_emit      = w_word_full || w_final;
    assign w_step      = i_head_valid && (!w_emit || !r_out_valid || i_out_ready);
    assign o_pop       = w_step && w_seg_done && (w_phase == PH_SYM);

    // next phase
    always_comb begin
        n_busy   = r_busy;
        n_phase  = r_phase;
        n_remain = r_remain;
        n_sym    = r_sym;
        if (w_step) begin
            if (!w_seg_done) begin
                n_busy   = 1'b1;
                n_phase  = w_phase;
                n_remain = w_remain - REM_W'(w_take);
                n_sym    = w_sym >> w_take;
            end else begin
                case (w_phase)
                    PH_PAD: begin
                        n_busy = 1'b1;
                        if (i_head.preamble) begin
                            n_phase  = PH_PRE;
                            n_remain = REM_W'(PREAMBLE_BITS);
                        end else begin
                            n_phase  = PH_SYM;
                            n_remain = REM_W'(i_head.sym_cnt);
                            n_sym    = i_head.sym;
                        end
                    end
                    PH_PRE: begin
                        n_busy   = 1'b1;
                        n_phase  = PH_SYM;
                        n_remain = REM_W'(i_head.sym_cnt);
                        n_sym    = i_head.sym;
                    end
                    PH_SYM:  n_busy = 1'b0;
                    default: n_busy = 1'b0;
                endcase
            end
        end
    end

    // accumulator and output register
    always_comb begin
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_line_word = r_line_word;
        n_eof       = r_eof;
        n_lerr      = r_lerr;
        if (w_step) begin
            if (w_emit) begin
                n_acc       = '0;
                n_pos       = '0;
                n_out_valid = 1'b1;
                n_line_word = to_line(w_acc_new) ^ {w_final, 31'b0};
                n_eof       = w_final;
                n_lerr      = w_final ? i_head.lerr : i_head.drop;
            end else begin
                n_acc = w_acc_new;
                n_pos = r_pos + w_take[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_PAD;
            r_acc       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain    <= n_remain;
        r_sym       <= n_sym;
        r_line_word <= n_line_word;
        r_eof       <= n_eof;
        r_lerr      <= n_lerr;
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_word    = r_line_word;
    assign o_end_of_frame = r_eof;
    assign o_length_error = r_lerr;

endmodule
